FILE: src/tsvf_pkg.sv
package tsvf_pkg;

    localparam int GAIN_W     = 24;
    localparam int NORM_W     = 25;
    localparam int COEF_W     = 25;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 25;
    localparam int GAIN_SHIFT = 20;
    localparam int NORM_SHIFT = 24;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd32768;
    localparam logic [NORM_W-1:0] NORM_ONE   = 25'd16777216;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_GAIN = 1'b0,
        CFG_NORM = 1'b1
    } t_cfg_addr;

    // which of the three products is in flight
    typedef enum logic [1:0] {
        STEP_SUM = 2'd0,
        STEP_BP  = 2'd1,
        STEP_V   = 2'd2
    } t_step;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_L = 6'b000010,
        ST_MUL_H = 6'b000100,
        ST_FIN   = 6'b001000,
        ST_LP    = 6'b010000,
        ST_STORE = 6'b100000
    } t_state;

    typedef struct packed {
        logic  load;
        logic  mul_lo;
        logic  mul_hi;
        logic  fin;
        t_step step;
        logic  calc_lp;
        logic  store;
    } t_dp_cmd;

endpackage

FILE: src/tsvf_ctrl.sv
module tsvf_ctrl
    import tsvf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = STEP_SUM;
                    n_state    = ST_MUL_L;
                end
            end
            ST_MUL_L: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = ST_MUL_H;
            end
            ST_MUL_H: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.fin = 1'b1;
                case (r_step)
                    STEP_SUM: begin
                        n_step  = STEP_BP;
                        n_state = ST_MUL_L;
                    end
                    STEP_BP: begin
                        n_step  = STEP_V;
                        n_state = ST_MUL_L;
                    end
                    default: begin
                        n_state = ST_LP;
                    end
                endcase
            end
            ST_LP: begin
                o_cmd.calc_lp = 1'b1;
                n_state       = ST_STORE;
            end
            ST_STORE: begin
                if (out_free) begin
                    o_cmd.store = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_SUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: src/tsvf_dp.sv
module tsvf_dp
    import tsvf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int STATE_HEADROOM = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  t_dp_cmd                 i_cmd,
    output logic [SAMPLE_WIDTH-1:0] o_lowpass
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int SW = SAMPLE_WIDTH + STATE_HEADROOM;
    localparam int MW = SW;
    localparam int HW = (MW + 1) / 2;
    localparam int AW = MW + COEF_W;
    localparam int RW = MW + 6;
    localparam int EW = RW + 2;

    localparam logic signed [EW-1:0] ST_MAX_E = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [EW-1:0] ST_MIN_E = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMP_MAX  = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN  = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic [AW-1:0] HALF_GAIN = AW'(1) << (GAIN_SHIFT - 1);
    localparam logic [AW-1:0] HALF_NORM = AW'(1) << (NORM_SHIFT - 1);

    function automatic logic signed [SW-1:0] sat_st(input logic signed [EW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > ST_MAX_E) begin
            r = ST_MAX_E[SW-1:0];
        end else if (v < ST_MIN_E) begin
            r = ST_MIN_E[SW-1:0];
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] v);
        return v[SW-1] ? MW'(-v) : MW'(v);
    endfunction

    logic [GAIN_W-1:0]       r_gain;
    logic [NORM_W-1:0]       r_norm;
    logic signed [SW-1:0]    r_s1, r_s2, r_v, r_lp;
    logic [MW-1:0]           r_mag;
    logic                    r_neg;
    logic [COEF_W-1:0]       r_coef;
    logic [AW-1:0]           r_acc;
    logic [W-1:0]            r_out;

    logic [NORM_W-1:0]       d_eff;
    logic signed [EW-1:0]    diff;
    logic [2*HW-1:0]         mag_ext;
    logic [HW-1:0]           mul_a;
    logic [HW+COEF_W-1:0]    prod;
    logic [RW-2:0]           res_mag;
    logic signed [RW-1:0]    res_pos, res_s;
    logic signed [SW-1:0]    sum_sat, bp_new, s1_new, v_new, lp_new, s2_new;
    logic [W-1:0]            out_new;

    assign d_eff   = (r_norm > NORM_ONE) ? NORM_ONE : r_norm;
    assign diff    = EW'(signed'(i_sample)) - EW'(r_s2);
    assign mag_ext = (2*HW)'(r_mag);
    assign mul_a   = i_cmd.mul_hi ? mag_ext[2*HW-1:HW] : mag_ext[HW-1:0];
    assign prod    = mul_a * r_coef;

    assign res_mag = (i_cmd.step == STEP_BP) ? (RW-1)'(r_acc >> NORM_SHIFT)
                                             : (RW-1)'(r_acc >> GAIN_SHIFT);
    assign res_pos = signed'({1'b0, res_mag});
    assign res_s   = r_neg ? -res_pos : res_pos;

    assign sum_sat = sat_st(EW'(res_s) + EW'(r_s1));
    assign bp_new  = res_s[SW-1:0];
    assign s1_new  = sat_st((EW'(bp_new) <<< 1) - EW'(r_s1));
    assign v_new   = sat_st(EW'(res_s));
    assign lp_new  = sat_st(EW'(r_v) + EW'(r_s2));
    assign s2_new  = sat_st(EW'(r_v) + EW'(r_lp));

    always_comb begin
        if (r_lp > SMP_MAX) begin
            out_new = SMP_MAX[W-1:0];
        end else if (r_lp < SMP_MIN) begin
            out_new = SMP_MIN[W-1:0];
        end else begin
            out_new = r_lp[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RESET;
            r_norm <= NORM_ONE;
            r_s1   <= '0;
            r_s2   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_addr'(i_cfg_addr))
                    CFG_GAIN: r_gain <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_NORM: r_norm <= i_cfg_wdata[NORM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.fin && i_cmd.step == STEP_BP) begin
                r_s1 <= s1_new;
            end
            if (i_cmd.store) begin
                r_s2 <= s2_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag  <= diff[EW-1] ? MW'(-diff) : MW'(diff);
            r_neg  <= diff[EW-1];
            r_coef <= COEF_W'(r_gain);
        end
        if (i_cmd.mul_lo) begin
            r_acc <= AW'(prod) + ((i_cmd.step == STEP_BP) ? HALF_NORM : HALF_GAIN);
        end
        if (i_cmd.mul_hi) begin
            r_acc <= r_acc + (AW'(prod) << HW);
        end
        if (i_cmd.fin) begin
            case (i_cmd.step)
                STEP_SUM: begin
                    r_mag  <= mag_of(sum_sat);
                    r_neg  <= sum_sat[SW-1];
                    r_coef <= COEF_W'(d_eff);
                end
                STEP_BP: begin
                    r_mag  <= mag_of(bp_new);
                    r_neg  <= bp_new[SW-1];
                    r_coef <= COEF_W'(r_gain);
                end
                default: begin
                    r_v <= v_new;
                end
            endcase
        end
        if (i_cmd.calc_lp) begin
            r_lp <= lp_new;
        end
        if (i_cmd.store) begin
            r_out <= out_new;
        end
    end

    assign o_lowpass = r_out;

endmodule

FILE: src/tpt_svf_lowpass.sv
// Low-pass output of a trapezoidal two-integrator state variable filter.
// Input samples enter on the s_axis channel, one signed sample per item;
// each accepted item yields exactly one low-pass item on m_axis.
// Coefficients gain (index 0, Q4.20) and normalizer (index 1, Q1.24,
// values above 1.0 act as 1.0) are written through i_cfg_*; the user must
// write them only while idle, which the block itself does not enforce.
// An item runs accept, three products on one shared half-width multiplier
// (low half, high half, round and update), an lp step, and a store step
// that updates s2 and loads the output, which is then valid; s_axis_tready
// rises again in the same cycle, so a new item is taken only after the last.
// The output register holds a result until taken. If m_axis_tready is low
// when the next result is done, the block waits in its store step and
// takes no new item until the old result leaves.
// Synchronous reset clears both integrator states, drops any pending
// output and restores the coefficient reset values.
module tpt_svf_lowpass
    import tsvf_pkg::*;
#(
    parameter int SAMPLE_WIDTH   = 24,
    parameter int STATE_HEADROOM = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]               i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]               i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // sample_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata    // lowpass_out
);

    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

    t_dp_cmd                 cmd;
    logic [SAMPLE_WIDTH-1:0] lowpass;

    tsvf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    tsvf_dp #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .STATE_HEADROOM (STATE_HEADROOM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_cmd       (cmd),
        .o_lowpass   (lowpass)
    );

    assign m_axis_tdata = DW'(lowpass);

endmodule
